[rtl/rle_pkg.sv]
// Shared types and constants for the RLP item encoder.
package rle_pkg;

  localparam logic [1:0] CMD_STR  = 2'd0;
  localparam logic [1:0] CMD_INT  = 2'd1;
  localparam logic [1:0] CMD_LIST = 2'd2;
  localparam logic [1:0] CMD_DATA = 2'd3;

  localparam logic [7:0] STR_BASE       = 8'h80;
  localparam logic [7:0] STR_LONG_BASE  = 8'hb7;
  localparam logic [7:0] LIST_BASE      = 8'hc0;
  localparam logic [7:0] LIST_LONG_BASE = 8'hf7;
  localparam logic [7:0] BARE_LIMIT     = 8'h80;
  localparam logic [63:0] SHORT_LIMIT   = 64'd56;

  localparam int LEN_FIELD_OCTETS = 8;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_INT,
    MODE_LIST
  } mode_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HDR,
    BK_LEN,
    BK_TAIL
  } bk_state_t;

  // One burst of output words: optional header byte, then nlen big-endian
  // length bytes, then an optional tail byte.
  typedef struct packed {
    logic        hdr_en;
    logic [7:0]  hdr_byte;
    logic [3:0]  nlen;
    logic [63:0] len;
    logic        tail_en;
    logic [7:0]  tail_byte;
    logic        err;
  } rle_job_t;

endpackage

[rtl/rle_if.sv]
// Channel interfaces for the encoder's command input and byte output.
interface rle_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] length;
  logic [7:0]  data_byte;

  modport source (output valid, output cmd, output length, output data_byte, input ready);
  modport sink (input valid, input cmd, input length, input data_byte, output ready);
endinterface

interface rle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, output out_byte, output last, output error, input ready);
  modport sink (input valid, input out_byte, input last, input error, output ready);
endinterface

[rtl/rle_front.sv]
// Front end: accepts commands, tracks item state and builds output bursts.
module rle_front #(
  parameter int INT_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst,
  rle_cmd_if.sink           cmds,
  input  logic              full,
  output logic              push,
  output rle_pkg::rle_job_t job
);
  import rle_pkg::*;

  mode_t       mode;
  mode_t       mode_next;
  logic [63:0] remaining;
  logic [63:0] remaining_next;
  logic        seen_nonzero;
  logic        seen_nonzero_next;

  logic        accept;
  logic        emit;
  logic [63:0] dec_src;
  logic [63:0] dec;
  logic        hdr_short;
  logic [3:0]  nbytes;

  assign cmds.ready = !full;
  assign accept     = cmds.valid && cmds.ready;
  assign push       = accept && emit;

  assign dec_src   = (cmds.cmd == CMD_DATA) ? remaining : cmds.length;
  assign dec       = dec_src - 64'd1;
  assign hdr_short = cmds.length < SHORT_LIMIT;

  always_comb begin
    nbytes = '0;
    for (int i = 0; i < LEN_FIELD_OCTETS; i++) begin
      if (cmds.length[8*i +: 8] != 8'd0) begin
        nbytes = 4'(i + 1);
      end
    end
  end

  always_comb begin
    logic int_path;
    logic int_seen;
    logic left_one;
    job               = '0;
    emit              = 1'b0;
    mode_next         = mode;
    remaining_next    = remaining;
    seen_nonzero_next = seen_nonzero;
    int_path          = 1'b0;
    int_seen          = seen_nonzero;
    left_one          = (dec == 64'd0);
    job.len           = cmds.length;
    case (cmds.cmd)
      CMD_STR: begin
        seen_nonzero_next = 1'b0;
        mode_next         = MODE_IDLE;
        remaining_next    = '0;
        emit              = 1'b1;
        job.tail_en       = 1'b1;
        if (cmds.length == 64'd0) begin
          job.tail_byte = STR_BASE;
        end else if (cmds.length == 64'd1 && cmds.data_byte < BARE_LIMIT) begin
          job.tail_byte = cmds.data_byte;
        end else begin
          job.hdr_en     = 1'b1;
          job.hdr_byte   = hdr_short ? STR_BASE + cmds.length[7:0]
                                     : STR_LONG_BASE + 8'(nbytes);
          job.nlen       = hdr_short ? 4'd0 : nbytes;
          job.tail_byte  = cmds.data_byte;
          remaining_next = dec;
          mode_next      = (dec != 64'd0) ? MODE_STR : MODE_IDLE;
        end
      end
      CMD_INT: begin
        seen_nonzero_next = 1'b0;
        mode_next         = MODE_IDLE;
        remaining_next    = '0;
        if (cmds.length == 64'd0 || cmds.length > 64'(INT_BYTES)) begin
          emit        = 1'b1;
          job.tail_en = 1'b1;
          job.err     = 1'b1;
        end else begin
          int_path = 1'b1;
          int_seen = 1'b0;
        end
      end
      CMD_LIST: begin
        seen_nonzero_next = 1'b0;
        emit              = 1'b1;
        job.hdr_en        = 1'b1;
        job.hdr_byte      = hdr_short ? LIST_BASE + cmds.length[7:0]
                                      : LIST_LONG_BASE + 8'(nbytes);
        job.nlen          = hdr_short ? 4'd0 : nbytes;
        remaining_next    = cmds.length;
        mode_next         = (cmds.length == 64'd0) ? MODE_IDLE : MODE_LIST;
      end
      default: begin
        if (mode == MODE_IDLE || remaining == 64'd0) begin
          mode_next      = MODE_IDLE;
          remaining_next = '0;
          emit           = 1'b1;
          job.tail_en    = 1'b1;
          job.err        = 1'b1;
        end else if (mode == MODE_INT) begin
          int_path = 1'b1;
        end else begin
          emit           = 1'b1;
          job.tail_en    = 1'b1;
          job.tail_byte  = cmds.data_byte;
          remaining_next = dec;
          mode_next      = (dec == 64'd0) ? MODE_IDLE : mode;
        end
      end
    endcase

    // Integer bytes: leading zeros vanish; the first nonzero byte carries
    // the stripped-width header unless it is a lone byte below 0x80.
    if (int_path) begin
      if (int_seen) begin
        emit          = 1'b1;
        job.tail_en   = 1'b1;
        job.tail_byte = cmds.data_byte;
      end else if (cmds.data_byte == 8'd0) begin
        if (left_one) begin
          emit          = 1'b1;
          job.tail_en   = 1'b1;
          job.tail_byte = STR_BASE;
        end
      end else begin
        seen_nonzero_next = 1'b1;
        emit              = 1'b1;
        job.tail_en       = 1'b1;
        job.tail_byte     = cmds.data_byte;
        if (!(left_one && cmds.data_byte < BARE_LIMIT)) begin
          job.hdr_en   = 1'b1;
          job.hdr_byte = STR_BASE + dec_src[7:0];
        end
      end
      remaining_next = dec;
      mode_next      = (dec == 64'd0) ? MODE_IDLE : MODE_INT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      remaining    <= '0;
      seen_nonzero <= 1'b0;
    end else if (accept) begin
      mode         <= mode_next;
      remaining    <= remaining_next;
      seen_nonzero <= seen_nonzero_next;
    end
  end

endmodule

[rtl/rle_fifo.sv]
// Two-entry queue of output bursts between the front and back ends.
module rle_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rle_pkg::rle_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              job_valid,
  output rle_pkg::rle_job_t job
);
  import rle_pkg::*;

  rle_job_t   slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign job_valid = (count != 2'd0);
  assign job       = slots[rptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && job_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("Queue count out of range.");
  a_no_lost_push: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("Burst pushed into a full queue.");
  a_pop_has_job: assert property (@(posedge clk) disable iff (rst) pop |-> job_valid)
    else $error("Burst popped from an empty queue.");
`endif

endmodule

[rtl/rle_back.sv]
// Back end: expands queued bursts into output words through an output register.
module rle_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  rle_pkg::rle_job_t job,
  output logic              pop,
  rle_byte_if.source        stream
);
  import rle_pkg::*;

  bk_state_t   state;
  bk_state_t   state_next;
  logic [7:0]  hdr_byte;
  logic [63:0] len;
  logic        tail_en;
  logic [7:0]  tail_byte;
  logic        err;
  logic [3:0]  cnt;
  logic [2:0]  sel;

  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_err;

  logic        advance;
  logic        load;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        emit_err;

  assign advance = (state != BK_IDLE) && (!out_valid || stream.ready);
  assign load    = job_valid && ((state == BK_IDLE) || (advance && emit_last));
  assign pop     = load;
  assign sel     = 3'(cnt - 4'd1);

  always_comb begin
    emit_byte = tail_byte;
    emit_last = 1'b1;
    emit_err  = 1'b0;
    case (state)
      BK_HDR: begin
        emit_byte = hdr_byte;
        emit_last = (cnt == 4'd0) && !tail_en;
      end
      BK_LEN: begin
        emit_byte = len[{sel, 3'b000} +: 8];
        emit_last = (cnt == 4'd1) && !tail_en;
      end
      BK_TAIL: begin
        emit_byte = tail_byte;
        emit_err  = err;
      end
      default: begin
        emit_byte = tail_byte;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    if (load) begin
      state_next = job.hdr_en ? BK_HDR : BK_TAIL;
    end else if (advance) begin
      case (state)
        BK_HDR: begin
          if (cnt != 4'd0) begin
            state_next = BK_LEN;
          end else begin
            state_next = tail_en ? BK_TAIL : BK_IDLE;
          end
        end
        BK_LEN: begin
          if (cnt == 4'd1) begin
            state_next = tail_en ? BK_TAIL : BK_IDLE;
          end
        end
        default: begin
          state_next = BK_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        cnt <= job.nlen;
      end else if (advance && state == BK_LEN) begin
        cnt <= cnt - 4'd1;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hdr_byte  <= job.hdr_byte;
      len       <= job.len;
      tail_en   <= job.tail_en;
      tail_byte <= job.tail_byte;
      err       <= job.err;
    end
    if (advance) begin
      out_byte <= emit_byte;
      out_last <= emit_last;
      out_err  <= emit_err;
    end
  end

  assign stream.valid    = out_valid;
  assign stream.out_byte = out_byte;
  assign stream.last     = out_last;
  assign stream.error    = out_err;

`ifndef SYNTHESIS
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_err |-> out_last && out_byte == 8'd0)
    else $error("Error word is not a lone zero word.");
  a_len_count: assert property (@(posedge clk) disable iff (rst)
    state == BK_LEN |-> cnt != 4'd0)
    else $error("Length phase entered with no length bytes.");
  a_load_gap: assert property (@(posedge clk) disable iff (rst)
    load && state != BK_IDLE |-> advance && emit_last)
    else $error("New burst loaded before the current one finished.");
`endif

endmodule

[rtl/rlp_item_encoder.sv]
// Top level of the streaming RLP item encoder.
// The first word of an item passes through the burst queue, burst registers and output
// register; later words of the same burst follow one per cycle while the receiver is ready.
// Commands sustain one per cycle while each yields one word and ready is high; a header burst
// of up to ten words holds the back end and stalls intake once the two-entry queue fills.
// Synchronous reset returns the item state to idle and empties the queue and output register.
module rlp_item_encoder #(
  parameter int INT_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst,
  rle_cmd_if.sink    cmds,
  rle_byte_if.source stream
);
  import rle_pkg::*;

  logic     push;
  rle_job_t push_job;
  logic     full;
  logic     pop;
  logic     job_valid;
  rle_job_t job;

  rle_front #(
    .INT_BYTES(INT_BYTES)
  ) u_front (
    .clk (clk),
    .rst (rst),
    .cmds(cmds),
    .full(full),
    .push(push),
    .job (push_job)
  );

  rle_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .job_valid(job_valid),
    .job      (job)
  );

  rle_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job      (job),
    .pop      (pop),
    .stream   (stream)
  );

endmodule

[tb/rlp_item_encoder_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the streaming RLP item encoder, with directed and random commands.
module rlp_item_encoder_test;
  import rle_pkg::*;

  localparam int INT_WIDTH_MAX = 32;
  localparam int RANDOM_ITEMS = 180;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int SEND_IDLE_PCT [3] = '{18, 60, 0};
  localparam int RECV_IDLE_PCT [3] = '{60, 18, 0};

  typedef struct {
    logic [1:0]  cmd;
    logic [63:0] length;
    logic [7:0]  data;
    int          phase;
  } enc_cmd_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
    logic       err;
  } enc_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rle_cmd_if  cmds();
  rle_byte_if stream();

  rlp_item_encoder #(.INT_BYTES(INT_WIDTH_MAX)) dut (
    .clk    (clk),
    .rst    (rst),
    .cmds   (cmds),
    .stream (stream)
  );

  enc_cmd_t  pending_cmds[$];
  enc_word_t expected_words[$];
  enc_cmd_t  next_cmd;
  enc_word_t want_word;

  mode_t       enc_mode = MODE_IDLE;
  logic [63:0] enc_left = '0;
  logic        enc_nonzero = 1'b0;

  int fill_phase = 0;
  int cur_phase = 0;
  int n_queued = 0;
  int n_cmds = 0;
  int n_words = 0;
  int n_flagged = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch on %s at word %0d: got %h, expected %h", field, n_words, got, want);
    fail_count++;
  endtask

  function automatic void put_word(logic [7:0] value, logic err);
    enc_word_t w;
    w.value = value;
    w.last  = 1'b0;
    w.err   = err;
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void put_header(logic [63:0] len, logic [7:0] base,
                                     logic [7:0] long_base);
    logic [63:0] t = len;
    int n = 0;
    if (len < SHORT_LIMIT) begin
      put_word(base + len[7:0], 1'b0);
    end else begin
      while (t != 0) begin
        n++;
        t = t >> 8;
      end
      put_word(long_base + 8'(n), 1'b0);
      for (int i = n - 1; i >= 0; i--) put_word(8'(len >> (8 * i)), 1'b0);
    end
  endfunction

  // Leading zero bytes of an integer are swallowed until the first nonzero one.
  function automatic void put_int_byte(logic [7:0] b, logic [63:0] left);
    if (enc_nonzero) begin
      put_word(b, 1'b0);
    end else if (b == 8'h00) begin
      if (left == 64'd1) put_word(STR_BASE, 1'b0);
    end else begin
      enc_nonzero = 1'b1;
      if (left == 64'd1 && b < BARE_LIMIT) begin
        put_word(b, 1'b0);
      end else begin
        put_word(STR_BASE + left[7:0], 1'b0);
        put_word(b, 1'b0);
      end
    end
    enc_left = left - 1;
    enc_mode = (enc_left == 0) ? MODE_IDLE : MODE_INT;
  endfunction

  function automatic void predict_encoding(logic [1:0] cmd, logic [63:0] len, logic [7:0] b);
    int mark = expected_words.size();
    case (cmd)
      CMD_STR: begin
        enc_nonzero = 1'b0;
        enc_mode = MODE_IDLE;
        enc_left = '0;
        if (len == 0) begin
          put_word(STR_BASE, 1'b0);
        end else if (len == 1 && b < BARE_LIMIT) begin
          put_word(b, 1'b0);
        end else begin
          put_header(len, STR_BASE, STR_LONG_BASE);
          put_word(b, 1'b0);
          enc_left = len - 1;
          if (enc_left != 0) enc_mode = MODE_STR;
        end
      end
      CMD_INT: begin
        enc_nonzero = 1'b0;
        enc_mode = MODE_IDLE;
        enc_left = '0;
        if (len == 0 || len > INT_WIDTH_MAX) put_word(8'h00, 1'b1);
        else put_int_byte(b, len);
      end
      CMD_LIST: begin
        enc_nonzero = 1'b0;
        put_header(len, LIST_BASE, LIST_LONG_BASE);
        enc_left = len;
        enc_mode = (len == 0) ? MODE_IDLE : MODE_LIST;
      end
      default: begin
        if (enc_mode == MODE_IDLE || enc_left == 0) begin
          enc_mode = MODE_IDLE;
          enc_left = '0;
          put_word(8'h00, 1'b1);
        end else if (enc_mode == MODE_INT) begin
          put_int_byte(b, enc_left);
        end else begin
          put_word(b, 1'b0);
          enc_left = enc_left - 1;
          if (enc_left == 0) enc_mode = MODE_IDLE;
        end
      end
    endcase
    if (expected_words.size() > mark) expected_words[expected_words.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [63:0] rand_word64();
    return {$urandom, $urandom};
  endfunction

  task automatic add_cmd(input logic [1:0] cmd, input logic [63:0] len, input logic [7:0] b);
    enc_cmd_t c;
    c.cmd    = cmd;
    c.length = len;
    c.data   = b;
    c.phase  = fill_phase;
    pending_cmds.insert(pending_cmds.size(), c);
    n_queued++;
  endtask

  task automatic add_data(input logic [7:0] b);
    add_cmd(CMD_DATA, rand_word64(), b);
  endtask

  task automatic gen_string();
    int r = $urandom_range(0, 99);
    logic [63:0] len;
    int n_data;
    if (r < 88) len = 64'($urandom_range(0, 6));
    else if (r < 94) len = 64'($urandom_range(54, 58));
    else len = rand_word64() >> $urandom_range(0, 63);
    n_data = (len == 0) ? 0 : (len > 64) ? $urandom_range(0, 3) : int'(len) - 1;
    if (len <= 64 && $urandom_range(0, 9) == 0) n_data = $urandom_range(0, n_data);
    add_cmd(CMD_STR, len, 8'($urandom));
    repeat (n_data) add_data(8'($urandom));
  endtask

  task automatic gen_integer();
    int r = $urandom_range(0, 99);
    int width;
    int lead;
    int n_data;
    if (r < 65) width = $urandom_range(1, 4);
    else if (r < 90) width = $urandom_range(5, INT_WIDTH_MAX);
    else if (r < 95) width = 0;
    else width = $urandom_range(INT_WIDTH_MAX + 1, 255);
    if (width >= 1 && width <= INT_WIDTH_MAX) begin
      lead = ($urandom_range(0, 6) == 0) ? width : $urandom_range(0, width - 1);
      n_data = width - 1;
      if ($urandom_range(0, 9) == 0) n_data = $urandom_range(0, n_data);
    end else begin
      lead = 0;
      n_data = $urandom_range(0, 1);
    end
    add_cmd(CMD_INT, 64'(width), (lead > 0) ? 8'h00 : 8'($urandom));
    for (int i = 1; i <= n_data; i++) add_data((i < lead) ? 8'h00 : 8'($urandom));
  endtask

  task automatic gen_list();
    int r = $urandom_range(0, 99);
    logic [63:0] len;
    int n_data;
    if (r < 80) begin
      len = 64'($urandom_range(0, 5));
      n_data = int'(len) + (($urandom_range(0, 9) == 0) ? 1 : 0);
    end else begin
      if (r < 90) len = 64'($urandom_range(55, 57));
      else len = rand_word64() >> $urandom_range(0, 63);
      n_data = (len < 3) ? int'(len) : $urandom_range(0, 2);
    end
    add_cmd(CMD_LIST, len, 8'($urandom));
    repeat (n_data) add_data(8'($urandom));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cmds.valid <= 1'b0;
    end else begin
      if (cmds.valid && cmds.ready) begin
        predict_encoding(cmds.cmd, cmds.length, cmds.data_byte);
        n_cmds++;
      end
      if (!cmds.valid || cmds.ready) begin
        if (pending_cmds.size() != 0 &&
            $urandom_range(0, 99) >= SEND_IDLE_PCT[pending_cmds[0].phase]) begin
          next_cmd = pending_cmds.pop_front();
          cmds.valid <= 1'b1;
          cmds.cmd <= next_cmd.cmd;
          cmds.length <= next_cmd.length;
          cmds.data_byte <= next_cmd.data;
          cur_phase <= next_cmd.phase;
        end else begin
          cmds.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stream.ready <= 1'b0;
    end else begin
      stream.ready <= $urandom_range(0, 99) >= RECV_IDLE_PCT[cur_phase];
    end
  end

  always @(posedge clk) begin
    if (!rst && stream.valid && stream.ready) begin
      n_words++;
      if (stream.error) n_flagged++;
      if (expected_words.size() == 0) begin
        report_mismatch("out_byte with nothing expected", stream.out_byte, 8'h00);
      end else begin
        want_word = expected_words.pop_front();
        if (stream.out_byte !== want_word.value)
          report_mismatch("out_byte", stream.out_byte, want_word.value);
        if (stream.last !== want_word.last)
          report_mismatch("last", 8'(stream.last), 8'(want_word.last));
        if (stream.error !== want_word.err)
          report_mismatch("error", 8'(stream.error), 8'(want_word.err));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmds.valid && cmds.ready) || (stream.valid && stream.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
               STALL_LIMIT, expected_words.size());
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int target;
    int r;
    cmds.valid = 1'b0;
    cmds.cmd = CMD_STR;
    cmds.length = '0;
    cmds.data_byte = '0;
    stream.ready = 1'b0;

    add_data(8'hA5);
    add_cmd(CMD_STR, 64'd0, 8'hFF);
    add_cmd(CMD_STR, 64'd1, 8'h00);
    add_cmd(CMD_STR, 64'd1, 8'h7F);
    add_cmd(CMD_STR, 64'd1, 8'h80);
    add_cmd(CMD_STR, 64'd2, 8'h12);
    add_data(8'hFE);
    add_cmd(CMD_STR, 64'd55, 8'h01);
    add_cmd(CMD_STR, 64'd56, 8'h02);
    add_cmd(CMD_STR, '1, 8'h55);
    add_cmd(CMD_LIST, 64'h8000_0000_0000_0000, 8'hAA);
    add_cmd(CMD_LIST, 64'd0, 8'h00);
    add_cmd(CMD_LIST, 64'd56, 8'hFF);
    add_cmd(CMD_LIST, 64'd3, 8'h00);
    add_data(8'hC1);
    add_data(8'h00);
    add_data(8'hFF);
    add_data(8'h3C);
    add_cmd(CMD_INT, 64'd0, 8'h01);
    add_cmd(CMD_INT, 64'(INT_WIDTH_MAX + 1), 8'h01);
    add_cmd(CMD_INT, '1, 8'hFF);
    add_cmd(CMD_INT, 64'd1, 8'h00);
    add_cmd(CMD_INT, 64'd1, 8'h7F);
    add_cmd(CMD_INT, 64'd1, 8'h80);
    add_cmd(CMD_INT, 64'd3, 8'h00);
    add_data(8'h00);
    add_data(8'h05);
    add_cmd(CMD_INT, 64'd2, 8'h00);
    add_data(8'h90);

    for (fill_phase = 0; fill_phase < 3; fill_phase++) begin
      target = n_queued + RANDOM_ITEMS / 3;
      while (n_queued < target) begin
        r = $urandom_range(0, 99);
        if (r < 30) gen_string();
        else if (r < 60) gen_integer();
        else if (r < 85) gen_list();
        else add_data(8'($urandom));
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending_cmds.size() != 0 || cmds.valid || expected_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Encoded %0d commands (strings, integers, lists, stray bytes) into %0d words,",
             n_cmds, n_words);
    $display("%0d of them flagged, under sender-heavy, receiver-heavy and no-idle handshakes.",
             n_flagged);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
